// ----- rtl/nfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types and constants for the next-fit block allocator.
// ----------------------------------------------------------------------------
package nfa_pkg;

	localparam int MAX_BLOCKS_DEF = 256;
	localparam int COUNT_W        = 9;
	localparam int INDEX_W        = 8;
	localparam int CFG_W          = 9;
	localparam int FIRST_W        = 8;

	typedef enum logic [0:0] {
		ACT_TAKE    = 1'b0,
		ACT_RELEASE = 1'b1
	} nfa_act_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_SPACE    = 2'd1,
		STAT_BAD_RELEASE = 2'd2
	} nfa_status_t;

	typedef struct packed {
		nfa_act_t               action;
		logic [COUNT_W-1:0]     count;
		logic [INDEX_W-1:0]     block_index;
	} nfa_req_t;

	typedef struct packed {
		nfa_status_t            status;
		logic [FIRST_W-1:0]     first_block;
	} nfa_rsp_t;

	// compare flags from the shared add unit
	typedef struct packed {
		logic gt;
		logic lt;
	} nfa_cmp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REL,
		S_CHECK,
		S_HEAD,
		S_SCAN,
		S_DONE
	} nfa_state_t;

endpackage
`default_nettype wire

// ----- rtl/nfa_run_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_run_mem
// Run-length store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nfa_run_mem #(
	parameter int DEPTH = nfa_pkg::MAX_BLOCKS_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = nfa_pkg::COUNT_W
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/nfa_add_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_add_unit
// Shared adder with a magnitude compare of the sum against a limit.
// ----------------------------------------------------------------------------
module nfa_add_unit #(
	parameter int A_W = 9,
	parameter int B_W = nfa_pkg::COUNT_W,
	parameter int S_W = 10
) (
	input  wire logic [A_W-1:0] a,
	input  wire logic [B_W-1:0] b,
	input  wire logic [S_W-1:0] lim,
	output logic      [S_W-1:0] sum,
	output nfa_pkg::nfa_cmp_t   cmp
);

	always_comb begin
		sum    = S_W'(a) + S_W'(b);
		cmp.gt = (sum > lim);
		cmp.lt = (sum < lim);
	end

endmodule
`default_nettype wire

// ----- rtl/nfa_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_seq
// Sequencer: clearing pass, next-fit scan, release and result register.
// ----------------------------------------------------------------------------
module nfa_seq #(
	parameter int MAX_BLOCKS = nfa_pkg::MAX_BLOCKS_DEF,
	parameter int IW = $clog2(MAX_BLOCKS),
	parameter int CW = $clog2(MAX_BLOCKS + 1),
	parameter int LW = nfa_pkg::COUNT_W,
	parameter int SW = ((CW > LW) ? CW : LW) + 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [nfa_pkg::CFG_W-1:0]  cfg_wr_data,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire nfa_pkg::nfa_req_t          req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output nfa_pkg::nfa_rsp_t               rsp,
	output logic                            mem_we,
	output logic      [IW-1:0]              mem_waddr,
	output logic      [LW-1:0]              mem_wdata,
	output logic      [IW-1:0]              mem_raddr,
	input  wire logic [LW-1:0]              mem_rdata,
	output logic      [CW-1:0]              add_a,
	output logic      [LW-1:0]              add_b,
	output logic      [SW-1:0]              add_lim,
	input  wire logic [SW-1:0]              add_sum,
	input  wire nfa_pkg::nfa_cmp_t          add_cmp
);

	nfa_pkg::nfa_state_t state_q, state_d;
	logic [IW-1:0]       rover_q, rover_d;
	logic [CW-1:0]       n_q, n_d;
	logic [IW-1:0]       clr_q, clr_d;
	logic                retry_q, retry_d;
	logic                rsp_valid_q, rsp_valid_d;
	logic [CW-1:0]       r_q, r_d;
	logic [CW-1:0]       j_q, j_d;
	logic [LW-1:0]       k_q, k_d;
	logic [SW-1:0]       end_q, end_d;
	nfa_pkg::nfa_rsp_t   res_q, res_d;
	nfa_pkg::nfa_rsp_t   rsp_q, rsp_d;
	logic [31:0]         r_wide;
	logic                hit;

	assign req_ready = (state_q == nfa_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign r_wide    = 32'(r_q);
	assign hit       = (mem_rdata != '0);

	always_comb begin
		state_d     = state_q;
		rover_d     = rover_q;
		n_d         = n_q;
		clr_d       = clr_q;
		retry_d     = retry_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		r_d         = r_q;
		j_d         = j_q;
		k_d         = k_q;
		end_d       = end_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_raddr   = '0;
		add_a       = '0;
		add_b       = '0;
		add_lim     = '0;

		// block count saturates at the built capacity
		if (cfg_wr_en) begin
			if (32'(cfg_wr_data) > MAX_BLOCKS) begin
				n_d = CW'(MAX_BLOCKS);
			end else begin
				n_d = CW'(cfg_wr_data);
			end
		end

		unique case (state_q)
			nfa_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + 1'b1;
				if (clr_q == IW'(MAX_BLOCKS - 1)) begin
					state_d = nfa_pkg::S_IDLE;
				end
			end
			nfa_pkg::S_IDLE: begin
				if (req_valid) begin
					res_d.first_block = '0;
					if (req.action == nfa_pkg::ACT_RELEASE) begin
						if (32'(req.block_index) >= MAX_BLOCKS) begin
							res_d.status = nfa_pkg::STAT_BAD_RELEASE;
							state_d      = nfa_pkg::S_DONE;
						end else begin
							mem_raddr = IW'(req.block_index);
							r_d       = CW'(req.block_index);
							state_d   = nfa_pkg::S_REL;
						end
					end else if ((req.count == '0) || (32'(req.count) > 32'(n_q))) begin
						res_d.status = nfa_pkg::STAT_NO_SPACE;
						state_d      = nfa_pkg::S_DONE;
					end else begin
						k_d     = req.count;
						r_d     = CW'(rover_q);
						retry_d = 1'b1;
						state_d = nfa_pkg::S_CHECK;
					end
				end
			end
			nfa_pkg::S_REL: begin
				if (hit) begin
					mem_we       = 1'b1;
					mem_waddr    = r_q[IW-1:0];
					res_d.status = nfa_pkg::STAT_OK;
				end else begin
					res_d.status = nfa_pkg::STAT_BAD_RELEASE;
				end
				state_d = nfa_pkg::S_DONE;
			end
			nfa_pkg::S_CHECK: begin
				add_a   = r_q;
				add_b   = k_q;
				add_lim = SW'(n_q);
				if (add_cmp.gt) begin
					if (retry_q) begin
						// run does not fit before the end: restart once from block 0
						r_d     = '0;
						retry_d = 1'b0;
					end else begin
						rover_d      = '0;
						res_d.status = nfa_pkg::STAT_NO_SPACE;
						state_d      = nfa_pkg::S_DONE;
					end
				end else begin
					end_d     = add_sum;
					retry_d   = 1'b0;
					mem_raddr = r_q[IW-1:0];
					state_d   = nfa_pkg::S_HEAD;
				end
			end
			nfa_pkg::S_HEAD, nfa_pkg::S_SCAN: begin
				add_a   = (state_q == nfa_pkg::S_HEAD) ? r_q : j_q;
				add_b   = hit ? mem_rdata : LW'(1);
				add_lim = end_q;
				if (hit) begin
					// skip past the run that starts here
					r_d     = CW'(add_sum);
					state_d = nfa_pkg::S_CHECK;
				end else if (add_cmp.lt) begin
					j_d       = CW'(add_sum);
					mem_raddr = add_sum[IW-1:0];
					state_d   = nfa_pkg::S_SCAN;
				end else begin
					mem_we            = 1'b1;
					mem_waddr         = r_q[IW-1:0];
					mem_wdata         = k_q;
					res_d.status      = nfa_pkg::STAT_OK;
					res_d.first_block = r_wide[nfa_pkg::FIRST_W-1:0];
					rover_d           = (end_q == SW'(n_q)) ? '0 : IW'(end_q);
					state_d           = nfa_pkg::S_DONE;
				end
			end
			nfa_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d       = res_q;
					rsp_valid_d = 1'b1;
					state_d     = nfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nfa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nfa_pkg::S_CLEAR;
			rover_q     <= '0;
			n_q         <= CW'(MAX_BLOCKS);
			clr_q       <= '0;
			retry_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rover_q     <= rover_d;
			n_q         <= n_d;
			clr_q       <= clr_d;
			retry_q     <= retry_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		r_q   <= r_d;
		j_q   <= j_d;
		k_q   <= k_d;
		end_q <= end_d;
		res_q <= res_d;
		rsp_q <= rsp_d;
	end

endmodule
`default_nettype wire

// ----- rtl/next_fit_block_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator of contiguous block runs with release.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of its run-length memory and
// takes no beat meanwhile. It works on one request at a time. A release
// reads the named block's run length in S_REL and clears it if nonzero. A
// take checks the fit in S_CHECK, reads blocks in S_HEAD and S_SCAN, goes
// back to S_CHECK past each run it skips and restarts once at block 0; a
// refused take goes to S_DONE. The single read port of the run-length
// memory sets the pace: the scan reads one block per cycle through the
// shared adder. The result sits in an output register, so the next request
// can be accepted while the previous result waits.
module next_fit_block_allocator #(
	parameter int MAX_BLOCKS = nfa_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [nfa_pkg::CFG_W-1:0] cfg_wr_data,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire nfa_pkg::nfa_req_t         req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	output nfa_pkg::nfa_rsp_t              rsp
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int LW = nfa_pkg::COUNT_W;
	localparam int SW = ((CW > LW) ? CW : LW) + 1;

	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [LW-1:0]     mem_wdata;
	logic [IW-1:0]     mem_raddr;
	logic [LW-1:0]     mem_rdata;
	logic [CW-1:0]     add_a;
	logic [LW-1:0]     add_b;
	logic [SW-1:0]     add_lim;
	logic [SW-1:0]     add_sum;
	nfa_pkg::nfa_cmp_t add_cmp;

	nfa_seq #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.IW         (IW),
		.CW         (CW),
		.LW         (LW),
		.SW         (SW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.add_a       (add_a),
		.add_b       (add_b),
		.add_lim     (add_lim),
		.add_sum     (add_sum),
		.add_cmp     (add_cmp)
	);

	nfa_run_mem #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IW),
		.DW    (LW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	nfa_add_unit #(
		.A_W (CW),
		.B_W (LW),
		.S_W (SW)
	) u_add (
		.a   (add_a),
		.b   (add_b),
		.lim (add_lim),
		.sum (add_sum),
		.cmp (add_cmp)
	);

endmodule
`default_nettype wire

// ----- rtl/nfa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module nfa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire nfa_pkg::nfa_rsp_t         rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// one request in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// a new result beat appears only at the end of the work on an item
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result beat without work");

	// only a granted take names a first block
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != nfa_pkg::STAT_OK) |-> rsp.first_block == '0)
		else $error("failed result with nonzero first block");

endmodule

bind next_fit_block_allocator nfa_checker u_nfa_checker (.*);
`default_nettype wire

// ----- tb/sv/next_fit_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_block_allocator_tb
// Self-checking bench for the next-fit block allocator. A behavioral copy of
// the allocator predicts each response beat, and the bench compares it field
// by field. Stimulus covers refusals, gap skipping, wrap, register extremes,
// a long response stall and random take/release traffic under random idling.
// ----------------------------------------------------------------------------
module next_fit_block_allocator_tb;
	import nfa_pkg::*;

	localparam int MAX_BLOCKS  = MAX_BLOCKS_DEF;
	localparam int HOLD_CYCLES = 600;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data = '0;
	logic              req_valid   = 1'b0;
	logic              req_ready;
	nfa_req_t          req_beat    = '0;
	logic              rsp_valid;
	logic              rsp_ready   = 1'b0;
	nfa_rsp_t          rsp_beat;

	// allocator shadow state
	int                run_len [MAX_BLOCKS];
	int                rover;
	logic [CFG_W-1:0]  block_count;

	nfa_rsp_t          expected_rsp [$];
	int                err_count;
	int                items_sent;
	int                grants;
	int                refusals;
	int                frees;
	int                bad_frees;

	int                send_idle_pct;
	int                rsp_idle_pct;
	int                hold_asked;
	int                hold_served;
	int                hold_left;

	next_fit_block_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req_beat),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp_beat)
	);

	always #5 clk = ~clk;

	initial begin
		#(64'd60_000_000);
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		err_count++;
	endtask

	// next-fit allocation, one request
	function automatic nfa_rsp_t predict_alloc(input nfa_req_t r);
		nfa_rsp_t res;
		int       n;
		int       k;
		int       j;
		bit       blocked;
		res.status      = STAT_OK;
		res.first_block = '0;
		n = (block_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
		if (r.action == ACT_RELEASE) begin
			if (run_len[r.block_index] == 0) begin
				res.status = STAT_BAD_RELEASE;
				bad_frees++;
			end else begin
				run_len[r.block_index] = 0;
				frees++;
			end
			return res;
		end
		k = r.count;
		if (k == 0 || k > n) begin
			res.status = STAT_NO_SPACE;
			refusals++;
			return res;
		end
		if (rover + k > n)
			rover = 0;
		while (rover + k <= n) begin
			if (run_len[rover] != 0) begin
				rover += run_len[rover];
				continue;
			end
			// nearest later start inside the window ends this gap
			blocked = 1'b0;
			for (j = rover + 1; j < MAX_BLOCKS && j < rover + k; j++) begin
				if (run_len[j] != 0) begin
					blocked = 1'b1;
					break;
				end
			end
			if (blocked) begin
				rover = j + run_len[j];
				continue;
			end
			break;
		end
		if (rover + k > n || run_len[rover] != 0) begin
			rover = 0;
			res.status = STAT_NO_SPACE;
			refusals++;
			return res;
		end
		run_len[rover]  = k;
		res.first_block = rover[FIRST_W-1:0];
		grants++;
		rover = (rover + k == n) ? 0 : rover + k;
		return res;
	endfunction

	// caller sits at a rising edge; returns at the edge where the beat is taken
	task automatic send_req(input nfa_req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req_beat  <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_rsp.push_back(predict_alloc(item));
		items_sent++;
	endtask

	task automatic send_take(input int k);
		nfa_req_t r;
		r.action      = ACT_TAKE;
		r.count       = k[COUNT_W-1:0];
		r.block_index = INDEX_W'($urandom);
		send_req(r);
	endtask

	task automatic send_release(input int idx);
		nfa_req_t r;
		r.action      = ACT_RELEASE;
		r.count       = COUNT_W'($urandom);
		r.block_index = idx[INDEX_W-1:0];
		send_req(r);
	endtask

	task automatic wait_drained(input int extra);
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_block_count(input int value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[CFG_W-1:0];
		@(posedge clk);
		block_count = value[CFG_W-1:0];
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// mostly takes and releases of live runs, with some noise
	function automatic nfa_req_t pick_req();
		nfa_req_t r;
		int       n;
		int       roll;
		int       starts [$];
		r.action      = ACT_TAKE;
		r.count       = COUNT_W'($urandom);
		r.block_index = INDEX_W'($urandom);
		n    = (block_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
		roll = $urandom_range(99);
		for (int i = 0; i < MAX_BLOCKS; i++)
			if (run_len[i] != 0) starts.push_back(i);
		if (roll >= 50 && roll < 85 && starts.size() != 0) begin
			r.action      = ACT_RELEASE;
			r.block_index = INDEX_W'(starts[$urandom_range(starts.size() - 1)]);
		end else if (roll >= 85 && roll < 92) begin
			r.action = ACT_RELEASE;
		end else if (roll < 85) begin
			if (n == 0)
				r.count = COUNT_W'($urandom_range(8, 1));
			else if ($urandom_range(99) < 80)
				r.count = COUNT_W'($urandom_range((n / 4 > 1) ? n / 4 : 1, 1));
			else
				r.count = COUNT_W'($urandom_range(n, 1));
		end
		return r;
	endfunction

	// response checker
	always @(posedge clk) begin : check_rsp
		nfa_rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("response beat with nothing expected");
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_beat.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp_beat.status, want.status));
				if (rsp_beat.first_block !== want.first_block)
					report_mismatch($sformatf("first_block %0d, expected %0d",
						rsp_beat.first_block, want.first_block));
			end
		end
	end

	// response ready, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left   <= HOLD_CYCLES;
			rsp_ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	task automatic test_refusals();
		send_take(0);
		send_take(MAX_BLOCKS + 1);
		send_take(MAX_BLOCKS);
		send_take(1);
		send_release(0);
		send_release(0);
		send_release(MAX_BLOCKS - 1);
		wait_drained(4);
	endtask

	task automatic test_gaps_and_wrap();
		write_block_count(16);
		for (int i = 0; i < 4; i++)
			send_take(4);
		send_release(4);
		// gap at 4 too short, run past the end fails
		send_take(5);
		send_take(4);
		wait_drained(4);
	endtask

	task automatic test_register_extremes();
		write_block_count(0);
		send_take(1);
		wait_drained(4);
		// saturates to full capacity
		write_block_count(511);
		send_take(240);
		wait_drained(4);
		write_block_count(8);
		send_take(2);
		send_release(16);
		send_release(8);
		send_take(4);
		send_release(4);
		send_take(4);
		wait_drained(4);
		write_block_count(1);
		send_take(1);
		send_release(0);
		send_take(1);
		wait_drained(4);
	endtask

	task automatic test_backpressure();
		write_block_count(32);
		hold_asked <= hold_asked + 1;
		for (int i = 0; i < 30; i++)
			send_req(pick_req());
		wait_drained(4);
	endtask

	task automatic test_random(input int n_items, input int cfg, input int s_idle,
			input int r_idle);
		send_idle_pct = s_idle;
		rsp_idle_pct  = r_idle;
		write_block_count(cfg);
		for (int i = 0; i < n_items; i++)
			send_req(pick_req());
		wait_drained(4);
	endtask

	initial begin
		foreach (run_len[i]) run_len[i] = 0;
		rover         = 0;
		block_count   = MAX_BLOCKS;
		err_count     = 0;
		items_sent    = 0;
		grants        = 0;
		refusals      = 0;
		frees         = 0;
		bad_frees     = 0;
		send_idle_pct = 27;
		rsp_idle_pct  = 56;
		hold_asked    = 0;
		hold_served   = 0;
		hold_left     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_refusals();
		test_gaps_and_wrap();
		test_register_extremes();
		test_backpressure();
		test_random(300, 16, 27, 56);
		test_random(300, 37, 27, 56);
		test_random(300, 64, 56, 27);
		test_random(200, 5, 56, 27);
		test_random(250, 256, 0, 0);
		test_random(150, 511, 0, 0);
		test_random(100, 1, 0, 0);
		test_random(150, 24, 0, 0);
		wait_drained(2 * MAX_BLOCKS + 8);

		$display("Covered %0d requests: %0d grants, %0d refused takes, %0d frees,",
			items_sent, grants, refusals, frees);
		$display("%0d bad frees; block counts 0 to 511, gap skipping, wrap, long stall",
			bad_frees);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/nfa_pkg.sv
rtl/nfa_run_mem.sv
rtl/nfa_add_unit.sv
rtl/nfa_seq.sv
rtl/next_fit_block_allocator.sv
rtl/nfa_checker.sv
tb/sv/next_fit_block_allocator_tb.sv
